// File: rtl/mdu_pkg.sv
// Shared types, opcodes and widths for the multiply/divide unit.
package mdu_pkg;
  localparam int unsigned Stages = 16;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_IMUL = 2'd1,
    OP_DIV  = 2'd2,
    OP_IDIV = 2'd3
  } op_t;

  // Per-item context carried down the divider chain.
  typedef struct packed {
    logic        vld;
    op_t         op;
    logic        word;
    logic [15:0] ax;
    logic [15:0] dx;
    logic        q_neg;
    logic        r_neg;
    logic        ovf;
    logic        cof;
    logic [15:0] dvs;
    logic [31:0] acc;
  } cell_t;
endpackage

// File: rtl/mdu_if.sv
// Valid/ready channel interface with payload.
interface mdu_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/mdu_cell.sv
// One restoring-division cell: one quotient bit per stage.
module mdu_cell import mdu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  cell_t c_in,
  output cell_t c_out
);
  cell_t c_r, c_nxt;
  logic [16:0] diff;
  always_comb begin
    c_nxt = c_in;
    // Shift the partial remainder left one bit and try the divisor.
    diff = c_in.acc[31:15] - {1'b0, c_in.dvs};
    if (c_in.op == OP_DIV || c_in.op == OP_IDIV) begin
      if (!diff[16]) begin
        c_nxt.acc = {diff[15:0], c_in.acc[14:0], 1'b1};
      end else begin
        c_nxt.acc = {c_in.acc[30:0], 1'b0};
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end else if (en) begin
      c_r <= c_nxt;
    end
  end
  assign c_out = c_r;
endmodule

// File: rtl/mul_div_unit_8_16.sv
// Top level of the x86 style 8/16-bit multiply/divide unit.
// Input channel in_*: req_type, AX, DX, operand, word_mode; one beat a cycle while in_ready is high.
// Output channel out_*: new AX/DX, flag write enable, carry/overflow, divide
// fault. Every beat returns exactly one result beat, in order.
// The entry logic takes magnitudes, checks the divisor against the dividend
// high half (zero divisor and wide quotients fault there) and forms the full
// product of a multiply. A chain of 16 restoring cells then produces one
// quotient bit per cell; multiplies ride the same chain untouched so order
// holds. A result register at the end restores signs and range-checks.
// Pipeline: 17 register stages (16 cells plus the result register) lie
// between an accepted input beat and out_valid.
// Throughput: one beat per cycle while the receiver takes results.
// The whole chain advances only when the result register is empty or being
// drained, so a stalled receiver freezes every cell and in_ready drops.
// Reset clears all valid bits and holds in_ready low; payload registers are
// not reset.
module mul_div_unit_8_16 import mdu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mdu_if.sink   in_ch,
  mdu_if.source out_ch
);
  localparam int unsigned NC = Stages;
  typedef struct packed {
    logic        vld;
    logic [15:0] ax;
    logic [15:0] dx;
    logic        fw;
    logic        cof;
    logic        err;
  } res_t;

  logic [1:0]  in_req_type;
  logic [15:0] in_acc_low_in, in_acc_high_in, in_operand;
  logic        in_word_mode;
  assign {in_req_type, in_acc_low_in, in_acc_high_in, in_operand, in_word_mode}
    = in_ch.data;

  logic  adv;
  res_t  out_r, out_nxt;
  cell_t pipe [NC+1];
  // Advance the chain whenever the result slot frees up this cycle.
  assign adv = !out_r.vld || out_ch.ready;
  assign in_ch.ready = adv && rst_n;

  // Entry: take magnitudes for divides, form the product for multiplies.
  cell_t ent;
  logic  is_idiv, is_imul, is_mul;
  logic  dvd_neg, dvs_neg;
  logic [15:0] dvs_s;
  logic [31:0] dvd_s;
  logic signed [16:0] ma, mb;
  logic signed [33:0] prod;
  always_comb begin
    is_idiv = (in_req_type == OP_IDIV);
    is_imul = (in_req_type == OP_IMUL);
    is_mul = (in_req_type == OP_MUL) || (in_req_type == OP_IMUL);
    ent = '0;
    ent.vld = in_ch.valid;
    ent.op = op_t'(in_req_type);
    ent.word = in_word_mode;
    ent.ax = in_acc_low_in;
    ent.dx = in_acc_high_in;
    if (in_word_mode) begin
      dvd_neg = is_idiv && in_acc_high_in[15];
      dvs_neg = is_idiv && in_operand[15];
      dvd_s = {in_acc_high_in, in_acc_low_in};
      if (dvd_neg) dvd_s = -dvd_s;
      dvs_s = dvs_neg ? -in_operand : in_operand;
    end else begin
      dvd_neg = is_idiv && in_acc_low_in[15];
      dvs_neg = is_idiv && in_operand[7];
      dvd_s = {16'h0000, dvd_neg ? -in_acc_low_in : in_acc_low_in};
      dvs_s = {8'h00, dvs_neg ? -in_operand[7:0] : in_operand[7:0]};
    end
    ent.q_neg = dvd_neg ^ dvs_neg;
    ent.r_neg = dvd_neg;
    ent.dvs = dvs_s;
    // Zero divisor and quotients past 16 bits both show up here.
    ent.ovf = (dvd_s[31:16] >= dvs_s);
    ent.acc = dvd_s;
    // Sign-extend only for IMUL; MUL sees a zero top bit.
    if (in_word_mode) begin
      ma = {is_imul & in_acc_low_in[15], in_acc_low_in};
      mb = {is_imul & in_operand[15], in_operand};
    end else begin
      ma = {{9{is_imul & in_acc_low_in[7]}}, in_acc_low_in[7:0]};
      mb = {{9{is_imul & in_operand[7]}}, in_operand[7:0]};
    end
    prod = ma * mb;
    if (is_mul) begin
      ent.ovf = 1'b0;
      ent.acc = prod[31:0];
      if (in_word_mode) begin
        ent.cof = is_imul ? !((&prod[31:15]) || !(|prod[31:15])) : (|prod[31:16]);
      end else begin
        ent.cof = is_imul ? !((&prod[15:7]) || !(|prod[15:7])) : (|prod[15:8]);
      end
    end
  end

  // Divider cells: each shifts one quotient bit into acc.
  assign pipe[0] = ent;
  for (genvar g = 0; g < NC; g++) begin : g_chain
    mdu_cell u_cell (.clk(clk), .rst_n(rst_n), .en(adv), .c_in(pipe[g]),
                     .c_out(pipe[g+1]));
  end

  // Result formation from the last cell: restore signs, range-check.
  cell_t       tail;
  logic [15:0] q_mag, r_mag, q_s, r_s;
  logic        q_big;
  assign tail = pipe[NC];
  always_comb begin
    out_nxt = '0;
    out_nxt.vld = tail.vld;
    out_nxt.ax = tail.ax;
    out_nxt.dx = tail.dx;
    q_mag = tail.acc[15:0];
    r_mag = tail.acc[31:16];
    q_s = tail.q_neg ? -q_mag : q_mag;
    r_s = tail.r_neg ? -r_mag : r_mag;
    // Signed quotients fault at the most negative value too.
    if (tail.op == OP_IDIV) begin
      q_big = tail.word ? (q_mag > 16'h7FFF) : (q_mag > 16'h007F);
    end else begin
      q_big = !tail.word && (q_mag > 16'h00FF);
    end
    if (tail.op == OP_MUL || tail.op == OP_IMUL) begin
      out_nxt.fw = 1'b1;
      out_nxt.cof = tail.cof;
      out_nxt.ax = tail.acc[15:0];
      if (tail.word) out_nxt.dx = tail.acc[31:16];
    end else if (tail.ovf || q_big) begin
      // Fault: pass AX and DX through.
      out_nxt.err = 1'b1;
    end else if (tail.word) begin
      out_nxt.ax = q_s;
      out_nxt.dx = r_s;
    end else begin
      out_nxt.ax = {r_s[7:0], q_s[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld <= 1'b0;
    end else if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_r.vld;
  assign out_ch.data = {out_r.ax, out_r.dx, out_r.fw, out_r.cof, out_r.err};

  // Hold a stalled result beat and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data));
  // Accept input whenever the result slot is empty.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready);
  // Keep out_valid known once out of reset.
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(out_ch.valid));
endmodule

// File: sim/tb_mul_div_unit_8_16.sv
// Self-checking testbench for the 8/16-bit multiply/divide unit.
module tb_mul_div_unit_8_16;
  import mdu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One input beat: operation, AX, DX, operand, word/byte select.
  typedef struct packed {
    op_t         op;
    logic [15:0] ax;
    logic [15:0] dx;
    logic [15:0] src;
    logic        word;
  } mdu_req_t;

  // One result beat: new AX, new DX, flag write, carry/overflow, divide fault.
  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] dx;
    logic        fw;
    logic        cof;
    logic        err;
  } mdu_rsp_t;

  // Holds the expected results of accepted beats, oldest first.
  class mdu_scoreboard;
    mdu_rsp_t pending[$];
    bit       failed;

    // Compute the architectural result of one multiply or divide.
    function mdu_rsp_t arith_result(mdu_req_t r);
      mdu_rsp_t          e;
      logic [15:0]       s;
      longint            p, d, dv, q, rm;
      longint unsigned   ud, uq, ur;
      e = '{ax: r.ax, dx: r.dx, fw: 1'b0, cof: 1'b0, err: 1'b0};
      s = r.word ? r.src : {8'h00, r.src[7:0]};
      case (r.op)
        OP_MUL: begin
          e.fw = 1'b1;
          if (!r.word) begin
            ud = longint'(r.ax[7:0]) * longint'(s);
            e.ax = ud[15:0];
            e.cof = |ud[15:8];
          end else begin
            ud = longint'(r.ax) * longint'(s);
            e.ax = ud[15:0];
            e.dx = ud[31:16];
            e.cof = |ud[31:16];
          end
        end
        OP_IMUL: begin
          e.fw = 1'b1;
          if (!r.word) begin
            p = longint'($signed(r.ax[7:0])) * longint'($signed(s[7:0]));
            e.ax = p[15:0];
            e.cof = (p < -128) || (p > 127);
          end else begin
            p = longint'($signed(r.ax)) * longint'($signed(s));
            e.ax = p[15:0];
            e.dx = p[31:16];
            e.cof = (p < -32768) || (p > 32767);
          end
        end
        OP_DIV: begin
          if (s == 16'd0) begin
            e.err = 1'b1;
          end else if (!r.word) begin
            ud = r.ax;
            uq = ud / s;
            ur = ud % s;
            if (uq > 255) e.err = 1'b1;
            else e.ax = {ur[7:0], uq[7:0]};
          end else begin
            ud = {r.dx, r.ax};
            uq = ud / s;
            ur = ud % s;
            if (uq > 65535) e.err = 1'b1;
            else begin
              e.ax = uq[15:0];
              e.dx = ur[15:0];
            end
          end
        end
        default: begin
          dv = r.word ? longint'($signed(s)) : longint'($signed(s[7:0]));
          if (dv == 0) begin
            e.err = 1'b1;
          end else if (!r.word) begin
            d = longint'($signed(r.ax));
            q = d / dv;
            rm = d % dv;
            if (q < -127 || q > 127) e.err = 1'b1;
            else e.ax = {rm[7:0], q[7:0]};
          end else begin
            d = longint'($signed({r.dx, r.ax}));
            q = d / dv;
            rm = d % dv;
            if (q < -32767 || q > 32767) e.err = 1'b1;
            else begin
              e.ax = q[15:0];
              e.dx = rm[15:0];
            end
          end
        end
      endcase
      if (e.err) begin
        e.ax = r.ax;
        e.dx = r.dx;
      end
      return e;
    endfunction

    function void note_request(mdu_req_t r);
      pending.push_back(arith_result(r));
    endfunction

    function void check_result(mdu_rsp_t a);
      mdu_rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat ax=%h dx=%h", a.ax, a.dx);
        failed = 1'b1;
        return;
      end
      e = pending.pop_front();
      if (a.ax !== e.ax) begin
        $error("acc_low_out exp %h got %h", e.ax, a.ax); failed = 1'b1;
      end
      if (a.dx !== e.dx) begin
        $error("acc_high_out exp %h got %h", e.dx, a.dx); failed = 1'b1;
      end
      if (a.fw !== e.fw) begin
        $error("flags_written exp %b got %b", e.fw, a.fw); failed = 1'b1;
      end
      if (a.cof !== e.cof) begin
        $error("carry_overflow exp %b got %b", e.cof, a.cof); failed = 1'b1;
      end
      if (a.err !== e.err) begin
        $error("div_fault exp %b got %b", e.err, a.err); failed = 1'b1;
      end
    endfunction
  endclass

  localparam int RandItems = 1850;
  localparam int PipeDepth = 17;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mdu_if #(.W($bits(mdu_req_t))) in_ch ();
  mdu_if #(.W($bits(mdu_rsp_t))) out_ch ();

  mul_div_unit_8_16 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mdu_scoreboard sb = new();
  mdu_req_t      stim[$];
  int            sent_cnt = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  logic          recv_hold = 1'b0;
  int            n_directed;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  // Build a dividend from a chosen in-range quotient, divisor and remainder so
  // that most divides get past the fault checks.
  function automatic mdu_req_t good_divide(op_t op, logic word);
    mdu_req_t r;
    longint   dv, q, rm, d;
    longint   mag;
    r.op = op;
    r.word = word;
    r.src = 16'($urandom);
    r.dx = 16'($urandom);
    r.ax = 16'($urandom);
    if (op == OP_DIV) begin
      dv = word ? $urandom_range(65535, 1) : $urandom_range(255, 1);
      q = word ? $urandom_range(65535) : $urandom_range(255);
      rm = $urandom % dv;
    end else begin
      do dv = word ? longint'($signed(16'($urandom))) : longint'($signed(8'($urandom)));
      while (dv == 0);
      q = word ? longint'($urandom_range(65534)) - 32767
               : longint'($urandom_range(254)) - 127;
      mag = dv < 0 ? -dv : dv;
      rm = $urandom % mag;
      if ((q * dv < 0) || (q * dv == 0 && $urandom_range(1))) rm = -rm;
    end
    d = q * dv + rm;
    if (word) begin
      r.src = dv[15:0];
      {r.dx, r.ax} = d[31:0];
    end else begin
      r.src[7:0] = dv[7:0];
      r.ax = d[15:0];
    end
    return r;
  endfunction

  function automatic mdu_req_t rand_request();
    mdu_req_t r;
    op_t      op;
    op = op_t'($urandom_range(3));
    if ((op == OP_DIV || op == OP_IDIV) && $urandom_range(99) < 70)
      return good_divide(op, 1'($urandom_range(1)));
    r.op = op;
    r.ax = 16'($urandom);
    r.dx = 16'($urandom);
    r.src = 16'($urandom);
    r.word = 1'($urandom_range(1));
    // Sprinkle zero and all-ones operands.
    case ($urandom_range(9))
      0: r.src = 16'h0000;
      1: r.src = 16'hFFFF;
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_directed(op_t op, logic word, logic [15:0] ax,
                                       logic [15:0] dx, logic [15:0] src);
    mdu_req_t r;
    r = '{op: op, ax: ax, dx: dx, src: src, word: word};
    stim.push_back(r);
  endfunction

  // Sender: hold the beat until accepted, then advance, idling by phase.
  initial begin
    int i;
    while (!rst_n) @(posedge clk);
    i = 0;
    forever begin
      @(posedge clk);
      if (in_ch.valid && in_ch.ready) begin
        sb.note_request(mdu_req_t'(in_ch.data));
        i++;
        sent_cnt <= i;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (i < stim.size() && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= stim[i];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted result beat, stall by phase or hold-off.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(mdu_rsp_t'(out_ch.data));
      out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off early in the random part so the chain fills and
  // in_ready drops while the sender keeps offering beats.
  initial begin
    wait (sent_cnt >= n_directed + 20 && n_directed > 0);
    @(posedge clk);
    recv_hold <= 1'b1;
    repeat (200) @(posedge clk);
    recv_hold <= 1'b0;
  end

  // Walk through the idling phases as the run progresses.
  always @(posedge clk) begin
    if (sent_cnt < n_directed + 300) begin
      send_idle_pct <= 0;  recv_stall_pct <= 0;
    end else if (sent_cnt < n_directed + 700) begin
      send_idle_pct <= 58; recv_stall_pct <= 0;
    end else if (sent_cnt < n_directed + 1100) begin
      send_idle_pct <= 0;  recv_stall_pct <= 58;
    end else if (sent_cnt < n_directed + 1500) begin
      send_idle_pct <= 6;  recv_stall_pct <= 6;
    end else begin
      send_idle_pct <= 0;  recv_stall_pct <= 0;
    end
  end

  initial begin
    #2ms;
    $display("tb_mul_div_unit_8_16: FAIL");
    $finish;
  end

  initial begin
    // Extremes of both multiplies, byte and word.
    add_directed(OP_MUL,  1'b0, 16'h12FF, 16'hA5A5, 16'hABFF);
    add_directed(OP_MUL,  1'b1, 16'hFFFF, 16'h0000, 16'hFFFF);
    add_directed(OP_MUL,  1'b0, 16'h0010, 16'h1234, 16'h0F0F);
    add_directed(OP_IMUL, 1'b0, 16'h0080, 16'h0000, 16'h0080);
    add_directed(OP_IMUL, 1'b0, 16'h00FF, 16'hFFFF, 16'h0080);
    add_directed(OP_IMUL, 1'b1, 16'h8000, 16'h5555, 16'h8000);
    add_directed(OP_IMUL, 1'b1, 16'hFFFF, 16'h0000, 16'h7FFF);
    add_directed(OP_IMUL, 1'b1, 16'h0100, 16'h0000, 16'h0080);
    // Zero divisor, byte and word, including garbage in the operand high byte.
    add_directed(OP_DIV,  1'b0, 16'h1234, 16'hBEEF, 16'hFF00);
    add_directed(OP_DIV,  1'b1, 16'h1234, 16'hBEEF, 16'h0000);
    add_directed(OP_IDIV, 1'b0, 16'h8000, 16'h0001, 16'h7700);
    add_directed(OP_IDIV, 1'b1, 16'h0001, 16'h8000, 16'h0000);
    // Unsigned quotient overflow and the largest fitting word quotient.
    add_directed(OP_DIV,  1'b0, 16'h0100, 16'h0000, 16'h0001);
    add_directed(OP_DIV,  1'b0, 16'hFFFF, 16'h0000, 16'h00FF);
    add_directed(OP_DIV,  1'b1, 16'h0000, 16'h0001, 16'h0001);
    add_directed(OP_DIV,  1'b1, 16'hFFFF, 16'hFFFE, 16'hFFFF);
    // Signed: most negative quotient faults, one above it passes.
    add_directed(OP_IDIV, 1'b0, 16'hFF80, 16'h0000, 16'h0001);
    add_directed(OP_IDIV, 1'b0, 16'hFF81, 16'h0000, 16'h0001);
    add_directed(OP_IDIV, 1'b0, 16'h007F, 16'h0000, 16'h0001);
    add_directed(OP_IDIV, 1'b1, 16'h8000, 16'hFFFF, 16'h0001);
    add_directed(OP_IDIV, 1'b1, 16'h8001, 16'hFFFF, 16'h0001);
    add_directed(OP_IDIV, 1'b1, 16'h0000, 16'h8000, 16'hFFFF);
    // Negative dividends leave negative remainders.
    add_directed(OP_IDIV, 1'b0, 16'hFFF9, 16'h0000, 16'h0002);
    add_directed(OP_IDIV, 1'b1, 16'hFFF9, 16'hFFFF, 16'hFFFE);
    n_directed = stim.size();
    repeat (RandItems) stim.push_back(rand_request());

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (sent_cnt == stim.size());
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PipeDepth + 10) @(posedge clk);
    if (!sb.failed) begin
      $display("tb_mul_div_unit_8_16: PASS");
    end else begin
      $display("tb_mul_div_unit_8_16: FAIL");
    end
    $finish;
  end
endmodule
